[design/tlvd_pkg.sv]
// ----------------------------------------------------------------------------
// TLV deframer package
// Shared types, codes and defaults for the TLV stream deframer.
// ----------------------------------------------------------------------------
package tlvd_pkg;

    localparam int FRAME_BUFFER_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF        = 4;
    localparam int HDR_BYTES              = 5;

    localparam logic [7:0] TYPE_SET_NAME = 8'h01;
    localparam logic [7:0] TYPE_SEND     = 8'h02;

    localparam logic [11:0] MAX_PAYLOAD_RESET     = 12'd4091;
    localparam logic [4:0]  MAX_NAME_LENGTH_RESET = 5'd31;

    typedef enum logic [0:0] {
        REG_MAX_PAYLOAD     = 1'b0,
        REG_MAX_NAME_LENGTH = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        VERDICT_NONE       = 3'd0,
        VERDICT_NAME_OK    = 3'd1,
        VERDICT_BAD_NAME   = 3'd2,
        VERDICT_BROADCAST  = 3'd3,
        VERDICT_NEED_NAME  = 3'd4,
        VERDICT_UNKNOWN    = 3'd5,
        VERDICT_EMPTY_SEND = 3'd6
    } verdict_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_LAST     = 2'd1,
        KIND_EMPTY    = 2'd2,
        KIND_OVERSIZE = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [11:0] msg_length;
        logic [7:0]  payload_byte;
        kind_t       kind;
    } entry_t;

endpackage

[design/tlvd_front.sv]
// ----------------------------------------------------------------------------
// TLV deframer front end
// Takes one byte per cycle while the queue is not full, parses the header
// and pushes a classified queue entry per payload byte and per empty or oversize frame.
// ----------------------------------------------------------------------------
module tlvd_front #(
    parameter int FRAME_BUFFER_BYTES = tlvd_pkg::FRAME_BUFFER_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic [11:0]      max_payload,
    input  logic             queue_full,
    output logic             push,
    output tlvd_pkg::entry_t push_entry
);

    localparam int BUF_SPAN = FRAME_BUFFER_BYTES - tlvd_pkg::HDR_BYTES;
    localparam logic [11:0] BUF_LIMIT = (BUF_SPAN > 4095) ? 12'hFFF : 12'(BUF_SPAN);
    localparam logic [2:0] HC_LAST_LEN = 3'(tlvd_pkg::HDR_BYTES - 1);
    localparam logic [2:0] HC_PAYLOAD  = 3'(tlvd_pkg::HDR_BYTES);

    logic [2:0]  header_count_reg, header_count_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [11:0] len_low_reg, len_low_next;
    logic        len_high_reg, len_high_next;
    logic [11:0] remaining_reg, remaining_next;
    logic        dead_reg, dead_next;

    logic        accept;
    logic [11:0] limit;
    logic [11:0] shifted_low;
    logic        shifted_high;

    assign s_ready      = !queue_full;
    assign accept       = s_valid && s_ready;
    assign limit        = (max_payload > BUF_LIMIT) ? BUF_LIMIT : max_payload;
    assign shifted_low  = {len_low_reg[3:0], s_data_byte};
    assign shifted_high = len_high_reg || (len_low_reg[11:4] != 8'd0);

    always_comb begin
        header_count_next = header_count_reg;
        held_type_next    = held_type_reg;
        len_low_next      = len_low_reg;
        len_high_next     = len_high_reg;
        remaining_next    = remaining_reg;
        dead_next         = dead_reg;
        push              = 1'b0;
        push_entry        = '{msg_type: held_type_reg, msg_length: 12'd0,
                              payload_byte: 8'd0, kind: tlvd_pkg::KIND_EMPTY};
        if (accept && !dead_reg) begin
            priority if (header_count_reg == 3'd0) begin
                held_type_next    = s_data_byte;
                len_low_next      = 12'd0;
                len_high_next     = 1'b0;
                header_count_next = 3'd1;
            end else if (header_count_reg < HC_PAYLOAD) begin
                len_low_next  = shifted_low;
                len_high_next = shifted_high;
                if (header_count_reg == HC_LAST_LEN) begin
                    if (shifted_high || (shifted_low > limit)) begin
                        push              = 1'b1;
                        push_entry.kind   = tlvd_pkg::KIND_OVERSIZE;
                        dead_next         = 1'b1;
                        header_count_next = 3'd0;
                    end else if (shifted_low == 12'd0) begin
                        push              = 1'b1;
                        push_entry.kind   = tlvd_pkg::KIND_EMPTY;
                        header_count_next = 3'd0;
                    end else begin
                        remaining_next    = shifted_low;
                        header_count_next = HC_PAYLOAD;
                    end
                end else begin
                    header_count_next = header_count_reg + 3'd1;
                end
            end else if (header_count_reg == HC_PAYLOAD) begin
                push                    = 1'b1;
                push_entry.msg_length   = len_low_reg;
                push_entry.payload_byte = s_data_byte;
                if (remaining_reg <= 12'd1) begin
                    push_entry.kind   = tlvd_pkg::KIND_LAST;
                    remaining_next    = 12'd0;
                    header_count_next = 3'd0;
                end else begin
                    push_entry.kind = tlvd_pkg::KIND_PAYLOAD;
                    remaining_next  = remaining_reg - 12'd1;
                end
            end else begin
                header_count_next = 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg <= 3'd0;
            held_type_reg    <= 8'd0;
            len_low_reg      <= 12'd0;
            len_high_reg     <= 1'b0;
            remaining_reg    <= 12'd0;
            dead_reg         <= 1'b0;
        end else begin
            header_count_reg <= header_count_next;
            held_type_reg    <= held_type_next;
            len_low_reg      <= len_low_next;
            len_high_reg     <= len_high_next;
            remaining_reg    <= remaining_next;
            dead_reg         <= dead_next;
        end
    end

    a_dead_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        dead_reg |-> !push)
        else $error("Entry pushed after the stream went dead.");

    a_oversize_kills: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_entry.kind == tlvd_pkg::KIND_OVERSIZE) |=> dead_reg)
        else $error("Oversize report did not stop the stream.");

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (header_count_reg == HC_PAYLOAD) |-> (remaining_reg != 12'd0))
        else $error("Payload phase with no bytes remaining.");

endmodule

[design/tlvd_queue.sv]
// ----------------------------------------------------------------------------
// TLV deframer queue
// Short first-in first-out queue of classified entries between the front
// end and the back end.
// ----------------------------------------------------------------------------
module tlvd_queue #(
    parameter int QUEUE_DEPTH = tlvd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tlvd_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output tlvd_pkg::entry_t head_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(QUEUE_DEPTH);

    tlvd_pkg::entry_t store [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_DEPTH);
    assign head_valid = (count_reg != '0);
    assign head_entry = store[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("Item pushed into a full queue.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_DEPTH)
        else $error("Queue count out of range.");

endmodule

[design/tlvd_back.sv]
// ----------------------------------------------------------------------------
// TLV deframer back end
// Drains the queue, tracks whether a name is set, gives the verdict at
// frame end and holds the result register.
// ----------------------------------------------------------------------------
module tlvd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  tlvd_pkg::entry_t head_entry,
    output logic             pop,
    input  logic [4:0]       max_name_length,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_msg_type,
    output logic [11:0]      m_msg_length,
    output logic [7:0]       m_payload_byte,
    output logic             m_payload_valid,
    output logic             m_last,
    output logic [2:0]       m_verdict,
    output logic             m_oversize_error
);

    logic        valid_reg;
    logic        name_known_reg;
    logic [7:0]  type_reg;
    logic [11:0] length_reg;
    logic [7:0]  byte_reg;
    logic        pvalid_reg;
    logic        last_reg;
    logic [2:0]  verdict_reg;
    logic        over_reg;

    logic               frame_end;
    logic               name_ok;
    tlvd_pkg::verdict_t verdict;

    assign pop       = head_valid && (!valid_reg || m_ready);
    assign frame_end = (head_entry.kind == tlvd_pkg::KIND_LAST) ||
                       (head_entry.kind == tlvd_pkg::KIND_EMPTY);
    assign name_ok   = (head_entry.msg_length != 12'd0) &&
                       (head_entry.msg_length <= {7'd0, max_name_length});

    always_comb begin
        verdict = tlvd_pkg::VERDICT_NONE;
        if (frame_end) begin
            priority if (head_entry.msg_type == tlvd_pkg::TYPE_SET_NAME) begin
                verdict = name_ok ? tlvd_pkg::VERDICT_NAME_OK : tlvd_pkg::VERDICT_BAD_NAME;
            end else if (head_entry.msg_type == tlvd_pkg::TYPE_SEND) begin
                priority if (!name_known_reg) begin
                    verdict = tlvd_pkg::VERDICT_NEED_NAME;
                end else if (head_entry.msg_length != 12'd0) begin
                    verdict = tlvd_pkg::VERDICT_BROADCAST;
                end else begin
                    verdict = tlvd_pkg::VERDICT_EMPTY_SEND;
                end
            end else begin
                verdict = tlvd_pkg::VERDICT_UNKNOWN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            name_known_reg <= 1'b0;
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
                if (verdict == tlvd_pkg::VERDICT_NAME_OK) begin
                    name_known_reg <= 1'b1;
                end
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            type_reg    <= head_entry.msg_type;
            length_reg  <= head_entry.msg_length;
            byte_reg    <= head_entry.payload_byte;
            pvalid_reg  <= (head_entry.kind == tlvd_pkg::KIND_PAYLOAD) ||
                           (head_entry.kind == tlvd_pkg::KIND_LAST);
            last_reg    <= frame_end;
            verdict_reg <= verdict;
            over_reg    <= (head_entry.kind == tlvd_pkg::KIND_OVERSIZE);
        end
    end

    assign m_valid          = valid_reg;
    assign m_msg_type       = type_reg;
    assign m_msg_length     = length_reg;
    assign m_payload_byte   = byte_reg;
    assign m_payload_valid  = pvalid_reg;
    assign m_last           = last_reg;
    assign m_verdict        = verdict_reg;
    assign m_oversize_error = over_reg;

    a_verdict_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !last_reg) |-> (verdict_reg == tlvd_pkg::VERDICT_NONE))
        else $error("Verdict on a result that does not end a frame.");

    a_name_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        name_known_reg |=> name_known_reg)
        else $error("Name flag cleared without reset.");

endmodule

[design/tlv_stream_deframer.sv]
// ----------------------------------------------------------------------------
// TLV stream deframer
// Parses frames of a type byte, a four-byte big-endian length and payload,
// passes payload bytes on and gives a verdict at each frame end.
//
//   Channel   Ports                         Direction
//   input     s_valid s_ready s_data_byte   in, one byte per item
//   result    m_valid m_ready m_*           out, zero or one result per item
//   config    cfg_wr_en cfg_wr_index/data   in, write only
//
// One item is accepted per cycle while the queue has room; the entry for an
// accepted byte is written to the queue, then loaded into the result register.
// Throughput is set by the result register, which drains one entry a cycle while the result side is ready.
// A stalled result side fills the queue and then holds s_ready low.
// Reset clears parse state, the name flag, the dead flag and the result valid flag, and loads the config defaults.
// ----------------------------------------------------------------------------
module tlv_stream_deframer #(
    parameter int FRAME_BUFFER_BYTES = tlvd_pkg::FRAME_BUFFER_BYTES_DEF,
    parameter int QUEUE_DEPTH        = tlvd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_msg_type,
    output logic [11:0] m_msg_length,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_valid,
    output logic        m_last,
    output logic [2:0]  m_verdict,
    output logic        m_oversize_error,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_wr_index,
    input  logic [11:0] cfg_wr_data
);

    logic [11:0] max_payload_reg;
    logic [4:0]  max_name_length_reg;

    logic             push;
    tlvd_pkg::entry_t push_entry;
    logic             queue_full;
    logic             pop;
    logic             head_valid;
    tlvd_pkg::entry_t head_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg     <= tlvd_pkg::MAX_PAYLOAD_RESET;
            max_name_length_reg <= tlvd_pkg::MAX_NAME_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (tlvd_pkg::reg_index_t'(cfg_wr_index))
                tlvd_pkg::REG_MAX_PAYLOAD: begin
                    max_payload_reg <= cfg_wr_data;
                end
                tlvd_pkg::REG_MAX_NAME_LENGTH: begin
                    max_name_length_reg <= cfg_wr_data[4:0];
                end
                default: begin
                end
            endcase
        end
    end

    tlvd_front #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .max_payload (max_payload_reg),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    tlvd_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    tlvd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (head_valid),
        .head_entry       (head_entry),
        .pop              (pop),
        .max_name_length  (max_name_length_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_msg_type       (m_msg_type),
        .m_msg_length     (m_msg_length),
        .m_payload_byte   (m_payload_byte),
        .m_payload_valid  (m_payload_valid),
        .m_last           (m_last),
        .m_verdict        (m_verdict),
        .m_oversize_error (m_oversize_error)
    );

endmodule
